// ----- src/gda_pkg.sv -----
`timescale 1ns / 1ps

package gda_pkg;

  localparam int MAX_YEAR = 9999;
  localparam int MAX_LEAP =
    ((MAX_YEAR % 4 == 0) && ((MAX_YEAR % 100 != 0) || (MAX_YEAR % 400 == 0))) ? 1 : 0;
  // Serial day number of the last representable date, 31.12 of MAX_YEAR.
  localparam int LAST_SERIAL = MAX_YEAR * 365 + (MAX_YEAR + 3) / 4 - (MAX_YEAR + 99) / 100
                             + (MAX_YEAR + 399) / 400 + 365 + MAX_LEAP;

  localparam int DAYS_400Y     = 146097;
  localparam int DAYS_100Y_1ST = 36525;
  localparam int DAYS_100Y     = 36524;
  localparam int DAYS_4Y       = 1461;
  localparam int DAYS_4Y_SHORT = 1460;
  localparam int DAYS_YEAR     = 365;

  // Multiply-and-shift reciprocal for an exact divide by 100 of a 14 bit year.
  localparam int RECIP_100     = 5243;
  localparam int RECIP_100_SH  = 19;

  // Opcodes.
  localparam logic [1:0] OPC_DIFF = 2'd0;
  localparam logic [1:0] OPC_ADD  = 2'd1;
  localparam logic [1:0] OPC_SUB  = 2'd2;
  localparam logic [1:0] OPC_NONE = 2'd3;

  // Error codes.
  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_DATE  = 2'd1;
  localparam logic [1:0] ERR_RANGE = 2'd2;

  // Microprogram size and the jump targets.
  localparam int UCODE_LEN = 37;
  localparam int UPC_W     = $clog2(UCODE_LEN);

  localparam logic [UPC_W-1:0] UA_NEWSER = UPC_W'(11);
  localparam logic [UPC_W-1:0] UA_CENT   = UPC_W'(20);
  localparam logic [UPC_W-1:0] UA_YEAR_Q = UPC_W'(31);
  localparam logic [UPC_W-1:0] UA_YEAR   = UPC_W'(34);
  localparam logic [UPC_W-1:0] UA_MONTH  = UPC_W'(35);
  localparam logic [UPC_W-1:0] UA_DONE   = UPC_W'(36);

  typedef struct packed {
    logic [1:0]  opcode;
    logic [4:0]  day_a;
    logic [3:0]  month_a;
    logic [13:0] year_a;
    logic [4:0]  day_b;
    logic [3:0]  month_b;
    logic [13:0] year_b;
    logic [21:0] day_count;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  result_day;
    logic [3:0]  result_month;
    logic [13:0] result_year;
    logic [21:0] day_distance;
    logic [1:0]  error_code;
  } out_item_t;

  typedef enum logic [1:0] {
    Y_A,
    Y_B,
    Y_R
  } ysel_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_QUOT,
    OP_LEAP,
    OP_SER_A,
    OP_SER_B,
    OP_DIFF,
    OP_NEWSER,
    OP_CSUB,
    OP_CSUB_MON
  } dp_op_e;

  typedef enum logic [1:0] {
    SB_HOLD,
    SB_LOAD,
    SB_LOAD_LEAP,
    SB_SHR
  } sub_op_e;

  typedef enum logic [1:0] {
    IN_HOLD,
    IN_LOAD,
    IN_SHR
  } inc_op_e;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_JUMP,
    JC_GE,
    JC_NGE,
    JC_ERR,
    JC_OPNZ,
    JC_OP3,
    JC_FIN
  } jc_e;

  typedef struct packed {
    ysel_e             ysel;
    dp_op_e            op;
    sub_op_e           sub_op;
    inc_op_e           inc_op;
    logic [21:0]       kval;
    logic [13:0]       kinc;
    logic              leap_clr;
    logic              init;
    jc_e               jc;
    logic [UPC_W-1:0]  target;
  } cw_t;

  typedef struct packed {
    logic ge;
    logic err;
    logic op_diff;
    logic op_none;
  } dp_flags_t;

  localparam cw_t CW_NOP = '{
    ysel:     Y_A,
    op:       OP_NOP,
    sub_op:   SB_HOLD,
    inc_op:   IN_HOLD,
    kval:     '0,
    kinc:     '0,
    leap_clr: 1'b0,
    init:     1'b0,
    jc:       JC_NEXT,
    target:   '0
  };

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic lp);
    logic [4:0] r;
    if (m == 4'd2) begin
      r = lp ? 5'd29 : 5'd28;
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      r = 5'd30;
    end else if (m inside {[4'd1:4'd12]}) begin
      r = 5'd31;
    end else begin
      r = 5'd0;
    end
    return r;
  endfunction

  // Days of the whole months before month m in a common year.
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- src/gregorian_date_arithmetic_core.sv -----
`timescale 1ns / 1ps
// Port group   Role     Handshake                    Word type
// in           sink     in_valid_i / in_stall_o      in_item_t
// out          source   out_valid_o / out_stall_i    out_item_t
//
// A microcoded sequencer steps one control word per cycle, except while a
// finished word waits for the output register, over a datapath with one shared
// compare-and-subtract unit, so the time from acceptance to the result register
// follows the microprogram path of the word: day difference, unused opcode,
// invalid date, result out of range, or add or subtract, which depends on how
// many century, year and month subtractions the new date needs. The next word
// is taken in the cycle after a result is written at the earliest.
// Reset leaves the sequencer idle and the output register empty; nothing
// needs clearing. in_stall_o is high from acceptance until the result is
// written to the output register; a result waiting there does not hold off
// the next input word, but a finished word waits on its last step until the
// output register is free.

module gregorian_date_arithmetic_core import gda_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  cw_t       cw;
  dp_flags_t flags;
  out_item_t res;
  logic      busy;
  logic      fin;
  logic      start;
  logic      out_free;
  logic      out_valid_q;
  out_item_t out_data_q;

  assign start      = in_valid_i && !busy;
  assign in_stall_o = busy;
  assign out_free   = !out_valid_q || !out_stall_i;

  gda_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .flags_i    (flags),
    .out_free_i (out_free),
    .cw_o       (cw),
    .busy_o     (busy),
    .fin_o      (fin)
  );

  gda_dpath u_dpath (
    .clk_i   (clk_i),
    .start_i (start),
    .item_i  (in_data_i),
    .cw_i    (cw),
    .flags_o (flags),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- src/gda_dpath.sv -----
`timescale 1ns / 1ps

module gda_dpath import gda_pkg::*; (
  input  logic      clk_i,
  input  logic      start_i,
  input  in_item_t  item_i,
  input  cw_t       cw_i,
  output dp_flags_t flags_o,
  output out_item_t res_o
);

  in_item_t    item_q;
  logic [7:0]  q_q;
  logic [22:0] ymul_q;
  logic        leap_q;
  logic [11:0] lcnt_q;
  logic [22:0] sa_q;
  logic [22:0] r_q;
  logic [21:0] sub_q;
  logic [13:0] inc_q;
  logic [13:0] yr_q;
  logic [3:0]  mo_q;
  logic [1:0]  err_q;
  logic [21:0] dist_q;

  logic [13:0] yop;
  logic [4:0]  dsel;
  logic [3:0]  msel;
  logic [26:0] qprod;
  logic [13:0] rem_w;
  logic [6:0]  rem7;
  logic        leap_w;
  logic [12:0] c4, c100, c400, lcnt_w;
  logic [22:0] ser_w;
  logic        valid_w;
  logic [21:0] opnd;
  logic        ge;
  logic [23:0] s_add;
  logic        bad_w;
  logic [22:0] ns_m1;
  logic        ok;

  always_comb begin
    case (cw_i.ysel)
      Y_A:     yop = item_q.year_a;
      Y_B:     yop = item_q.year_b;
      default: yop = yr_q;
    endcase
    dsel = (cw_i.ysel == Y_A) ? item_q.day_a : item_q.day_b;
    msel = (cw_i.ysel == Y_A) ? item_q.month_a : item_q.month_b;
  end

  // Year split into centuries and the rest; gives the leap flag and the
  // count of leap years before the year (year 0 counts as leap).
  always_comb begin
    qprod  = 27'(yop) * 27'(RECIP_100);
    rem_w  = yop - 14'(q_q) * 14'd100;
    rem7   = rem_w[6:0];
    leap_w = (yop[1:0] == 2'd0) && ((rem7 != 7'd0) || (q_q[1:0] == 2'd0));
    c4     = 13'(yop[13:2]) + 13'(yop[1:0] != 2'd0);
    c100   = 13'(q_q) + 13'(rem7 != 7'd0);
    c400   = 13'(q_q[7:2]) + 13'((rem7 != 7'd0) || (q_q[1:0] != 2'd0));
    lcnt_w = c4 - c100 + c400;
  end

  always_comb begin
    ser_w = ymul_q + 23'(lcnt_q) + 23'(cum_days(msel))
          + 23'((msel > 4'd2) && leap_q) + 23'(dsel);
    valid_w = (msel inside {[4'd1:4'd12]}) && (yop <= 14'(MAX_YEAR))
           && (dsel != 5'd0) && (dsel <= month_days(msel, leap_q));
  end

  always_comb begin
    opnd = (cw_i.op == OP_CSUB_MON) ? 22'(month_days(mo_q, leap_q)) : sub_q;
    ge   = r_q >= {1'b0, opnd};
  end

  always_comb begin
    s_add = 24'(sa_q) + 24'(item_q.day_count);
    if (item_q.opcode == OPC_ADD) begin
      bad_w = s_add > 24'(LAST_SERIAL);
      ns_m1 = 23'(s_add - 24'd1);
    end else begin
      bad_w = {1'b0, item_q.day_count} >= sa_q;
      ns_m1 = sa_q - {1'b0, item_q.day_count} - 23'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      item_q <= item_i;
      err_q  <= ERR_OK;
    end
    if (cw_i.init) begin
      yr_q <= '0;
      mo_q <= 4'd1;
    end

    case (cw_i.sub_op)
      SB_LOAD:      sub_q <= cw_i.kval;
      SB_LOAD_LEAP: sub_q <= cw_i.kval + 22'(leap_q);
      SB_SHR:       sub_q <= sub_q >> 1;
      default:      sub_q <= sub_q;
    endcase

    case (cw_i.inc_op)
      IN_LOAD: inc_q <= cw_i.kinc;
      IN_SHR:  inc_q <= inc_q >> 1;
      default: inc_q <= inc_q;
    endcase

    case (cw_i.op)
      OP_QUOT: begin
        q_q    <= qprod[RECIP_100_SH +: 8];
        ymul_q <= 23'(yop) * 23'(DAYS_YEAR);
      end
      OP_LEAP: begin
        leap_q <= leap_w;
        lcnt_q <= lcnt_w[11:0];
      end
      OP_SER_A: begin
        sa_q <= ser_w;
        if (!valid_w) err_q <= ERR_DATE;
      end
      OP_SER_B: begin
        r_q <= ser_w;
        if (!valid_w) err_q <= ERR_DATE;
      end
      OP_DIFF: begin
        dist_q <= (sa_q >= r_q) ? 22'(sa_q - r_q) : 22'(r_q - sa_q);
      end
      OP_NEWSER: begin
        r_q <= ns_m1;
        if (bad_w) err_q <= ERR_RANGE;
      end
      OP_CSUB: begin
        if (ge) begin
          r_q  <= r_q - {1'b0, opnd};
          yr_q <= yr_q + inc_q;
          if (cw_i.leap_clr) leap_q <= 1'b0;
        end
      end
      OP_CSUB_MON: begin
        if (ge) begin
          r_q  <= r_q - {1'b0, opnd};
          mo_q <= mo_q + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign flags_o = '{
    ge:      ge,
    err:     err_q != ERR_OK,
    op_diff: item_q.opcode == OPC_DIFF,
    op_none: item_q.opcode == OPC_NONE
  };

  always_comb begin
    ok = (err_q == ERR_OK);
    res_o = '0;
    res_o.error_code = err_q;
    if (ok && item_q.opcode == OPC_DIFF) begin
      res_o.day_distance = dist_q;
    end
    if (ok && (item_q.opcode == OPC_ADD || item_q.opcode == OPC_SUB)) begin
      res_o.result_day   = r_q[4:0] + 5'd1;
      res_o.result_month = mo_q;
      res_o.result_year  = yr_q;
    end
  end

endmodule

// ----- src/gda_useq.sv -----
`timescale 1ns / 1ps

module gda_useq import gda_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  dp_flags_t flags_i,
  input  logic      out_free_i,
  output cw_t       cw_o,
  output logic      busy_o,
  output logic      fin_o
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  state_e            state_q;
  logic [UPC_W-1:0]  pc_q;
  logic [UPC_W-1:0]  pc_d;
  cw_t               rom_w;

  // Control store. Serial numbers are built first, then a new serial is
  // split by 400-year division, century, 4-year, year and month steps.
  function automatic cw_t ucode(input logic [UPC_W-1:0] a);
    cw_t w;
    w = CW_NOP;
    case (a)
      UPC_W'(0): begin
        w.jc = JC_OP3; w.target = UA_DONE;
      end
      UPC_W'(1): begin
        w.ysel = Y_A; w.op = OP_QUOT;
      end
      UPC_W'(2): begin
        w.ysel = Y_A; w.op = OP_LEAP;
      end
      UPC_W'(3): begin
        w.ysel = Y_A; w.op = OP_SER_A;
      end
      UPC_W'(4), UPC_W'(9), UPC_W'(12): begin
        w.jc = JC_ERR; w.target = UA_DONE;
      end
      UPC_W'(5): begin
        w.jc = JC_OPNZ; w.target = UA_NEWSER;
      end
      UPC_W'(6): begin
        w.ysel = Y_B; w.op = OP_QUOT;
      end
      UPC_W'(7): begin
        w.ysel = Y_B; w.op = OP_LEAP;
      end
      UPC_W'(8): begin
        w.ysel = Y_B; w.op = OP_SER_B;
      end
      UPC_W'(10): begin
        w.op = OP_DIFF; w.jc = JC_JUMP; w.target = UA_DONE;
      end
      UPC_W'(11): begin
        w.op = OP_NEWSER;
      end
      UPC_W'(13): begin
        w.init   = 1'b1;
        w.sub_op = SB_LOAD; w.kval = 22'(DAYS_400Y * 16);
        w.inc_op = IN_LOAD; w.kinc = 14'(400 * 16);
      end
      UPC_W'(14), UPC_W'(15), UPC_W'(16), UPC_W'(17), UPC_W'(18),
      UPC_W'(26), UPC_W'(27), UPC_W'(28), UPC_W'(29), UPC_W'(30): begin
        w.op = OP_CSUB; w.sub_op = SB_SHR; w.inc_op = IN_SHR;
      end
      UPC_W'(19): begin
        w.sub_op = SB_LOAD; w.kval = 22'(DAYS_100Y_1ST);
        w.inc_op = IN_LOAD; w.kinc = 14'd100;
      end
      UPC_W'(20): begin
        // Only the first century of a 400-year cycle has the extra day.
        w.op = OP_CSUB; w.sub_op = SB_LOAD; w.kval = 22'(DAYS_100Y);
        w.jc = JC_GE; w.target = UA_CENT;
      end
      UPC_W'(21), UPC_W'(31): begin
        w.ysel = Y_R; w.op = OP_QUOT;
      end
      UPC_W'(22), UPC_W'(32): begin
        w.ysel = Y_R; w.op = OP_LEAP;
      end
      UPC_W'(23): begin
        w.sub_op = SB_LOAD_LEAP; w.kval = 22'(DAYS_4Y_SHORT);
        w.inc_op = IN_LOAD; w.kinc = 14'd4;
      end
      UPC_W'(24): begin
        w.op = OP_CSUB; w.jc = JC_NGE; w.target = UA_YEAR_Q;
      end
      UPC_W'(25): begin
        w.sub_op = SB_LOAD; w.kval = 22'(DAYS_4Y * 16);
        w.inc_op = IN_LOAD; w.kinc = 14'(4 * 16);
      end
      UPC_W'(33): begin
        w.sub_op = SB_LOAD_LEAP; w.kval = 22'(DAYS_YEAR);
        w.inc_op = IN_LOAD; w.kinc = 14'd1;
      end
      UPC_W'(34): begin
        // After the first year of a block the remaining years are common.
        w.op = OP_CSUB; w.sub_op = SB_LOAD; w.kval = 22'(DAYS_YEAR);
        w.leap_clr = 1'b1; w.jc = JC_GE; w.target = UA_YEAR;
      end
      UPC_W'(35): begin
        w.op = OP_CSUB_MON; w.jc = JC_GE; w.target = UA_MONTH;
      end
      default: begin
        w.jc = JC_FIN;
      end
    endcase
    return w;
  endfunction

  assign rom_w = ucode(pc_q);

  always_comb begin
    case (rom_w.jc)
      JC_JUMP: pc_d = rom_w.target;
      JC_GE:   pc_d = flags_i.ge ? rom_w.target : pc_q + UPC_W'(1);
      JC_NGE:  pc_d = !flags_i.ge ? rom_w.target : pc_q + UPC_W'(1);
      JC_ERR:  pc_d = flags_i.err ? rom_w.target : pc_q + UPC_W'(1);
      JC_OPNZ: pc_d = !flags_i.op_diff ? rom_w.target : pc_q + UPC_W'(1);
      JC_OP3:  pc_d = flags_i.op_none ? rom_w.target : pc_q + UPC_W'(1);
      JC_FIN:  pc_d = pc_q;
      default: pc_d = pc_q + UPC_W'(1);
    endcase
  end

  assign busy_o = (state_q == S_RUN);
  assign fin_o  = busy_o && (rom_w.jc == JC_FIN) && out_free_i;
  assign cw_o   = busy_o ? rom_w : CW_NOP;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_RUN;
            pc_q    <= '0;
          end
        end
        S_RUN: begin
          if (fin_o) begin
            state_q <= S_IDLE;
          end else begin
            pc_q <= pc_d;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/gda_checker.sv -----
`timescale 1ns / 1ps

module gda_checker import gda_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // One word is worked on at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again before the result was produced");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.error_code == ERR_OK || out_data_o.error_code == ERR_DATE
                     || out_data_o.error_code == ERR_RANGE))
    else $error("undefined error code");

  // An error word carries nothing but the error code.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.error_code != ERR_OK |->
      out_data_o.result_day == 5'd0 && out_data_o.result_month == 4'd0
      && out_data_o.result_year == 14'd0 && out_data_o.day_distance == 22'd0)
    else $error("error result with nonzero fields");

  // A date result is a real date and carries no distance.
  a_date_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_month != 4'd0 |->
      out_data_o.day_distance == 22'd0 && out_data_o.result_day != 5'd0
      && out_data_o.result_month <= 4'd12 && out_data_o.error_code == ERR_OK)
    else $error("malformed date result");

endmodule

bind gregorian_date_arithmetic_core gda_checker u_gda_checker (.*);

// ----- test/gda_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the date core, predicts the result word for every
// accepted input word and compares the results in order.
module gda_tb_checker import gda_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_data_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        checked_o
);

  out_item_t pending_results[$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
  end

  function automatic bit leap_year(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned month_length(int unsigned m, int unsigned y);
    case (m)
      2:         return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:   return 31;
    endcase
  endfunction

  function automatic bit date_ok(int unsigned d, int unsigned m, int unsigned y);
    if (m < 1 || m > 12 || y > MAX_YEAR) return 1'b0;
    return d >= 1 && d <= month_length(m, y);
  endfunction

  // Day number counted from 1.1.0000, which is day 1.
  function automatic int unsigned day_number(int unsigned d, int unsigned m,
                                             int unsigned y);
    int unsigned s;
    s = y * 365 + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    for (int unsigned k = 1; k < m; k++) s += month_length(k, y);
    return s + d;
  endfunction

  function automatic void day_to_date(int unsigned s, output int unsigned d,
                                      output int unsigned m, output int unsigned y);
    int unsigned r;
    r = s - 1;
    y = (r / 146097) * 400;
    r = r % 146097;
    m = 1;
    while (r >= (leap_year(y) ? 366 : 365)) begin
      r -= leap_year(y) ? 366 : 365;
      y++;
    end
    while (r >= month_length(m, y)) begin
      r -= month_length(m, y);
      m++;
    end
    d = r + 1;
  endfunction

  function automatic out_item_t predict_date_result(in_item_t w);
    out_item_t   res;
    int unsigned sa, sb, ns, last, rd, rm, ry;
    res = '0;
    if (w.opcode == OPC_DIFF) begin
      if (!date_ok(w.day_a, w.month_a, w.year_a)
          || !date_ok(w.day_b, w.month_b, w.year_b)) begin
        res.error_code = ERR_DATE;
      end else begin
        sa = day_number(w.day_a, w.month_a, w.year_a);
        sb = day_number(w.day_b, w.month_b, w.year_b);
        res.day_distance = 22'((sa > sb) ? sa - sb : sb - sa);
      end
    end else if (w.opcode == OPC_ADD || w.opcode == OPC_SUB) begin
      if (!date_ok(w.day_a, w.month_a, w.year_a)) begin
        res.error_code = ERR_DATE;
      end else begin
        sa   = day_number(w.day_a, w.month_a, w.year_a);
        last = day_number(31, 12, MAX_YEAR);
        if (w.opcode == OPC_ADD && sa + w.day_count > last) begin
          res.error_code = ERR_RANGE;
        end else if (w.opcode == OPC_SUB && w.day_count >= sa) begin
          res.error_code = ERR_RANGE;
        end else begin
          ns = (w.opcode == OPC_ADD) ? sa + w.day_count : sa - w.day_count;
          day_to_date(ns, rd, rm, ry);
          res.result_day   = 5'(rd);
          res.result_month = 4'(rm);
          res.result_year  = 14'(ry);
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  task automatic compare_result(out_item_t got, out_item_t want);
    if (got.result_day !== want.result_day)
      report_mismatch("result_day", got.result_day, want.result_day);
    if (got.result_month !== want.result_month)
      report_mismatch("result_month", got.result_month, want.result_month);
    if (got.result_year !== want.result_year)
      report_mismatch("result_year", got.result_year, want.result_year);
    if (got.day_distance !== want.day_distance)
      report_mismatch("day_distance", got.day_distance, want.day_distance);
    if (got.error_code !== want.error_code)
      report_mismatch("error_code", got.error_code, want.error_code);
  endtask

  // The input side is handled first so that a word is queued before its
  // result could be taken off the queue.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        pending_results.push_back(predict_date_result(in_data_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result word with nothing outstanding, error_code",
                          out_data_i.error_code, 0);
        end else begin
          compare_result(out_data_i, pending_results.pop_front());
        end
        checked_o++;
      end
      pending_o = pending_results.size();
    end
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import gda_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASE_WORDS  = 112;

  logic      clk_i;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int fail_count;
  int pending;
  int checked;
  int cycle_count;

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  bit          long_hold_req = 1'b0;

  gregorian_date_arithmetic_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  gda_tb_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off so the core backs up.
  initial begin : receiver
    int unsigned hold_count;
    bit          hold_done;
    hold_count = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req && !hold_done) begin
        out_stall <= 1'b1;
        hold_count++;
        if (hold_count == HOLD_CYCLES) hold_done = 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic in_item_t make_word(logic [1:0] op, int unsigned da, int unsigned ma,
                                         int unsigned ya, int unsigned db, int unsigned ma_b,
                                         int unsigned yb, int unsigned cnt);
    in_item_t w;
    w.opcode    = op;
    w.day_a     = 5'(da);
    w.month_a   = 4'(ma);
    w.year_a    = 14'(ya);
    w.day_b     = 5'(db);
    w.month_b   = 4'(ma_b);
    w.year_b    = 14'(yb);
    w.day_count = 22'(cnt);
    return w;
  endfunction

  // Mostly valid dates; late days of the month make some of them invalid.
  function automatic void random_date(output logic [4:0] d, output logic [3:0] m,
                                      output logic [13:0] y);
    int unsigned special[8] = '{0, 4, 100, 400, 1900, 2000, 2100, 9999};
    case ($urandom_range(7))
      0:       y = 14'(special[$urandom_range(7)]);
      1:       y = 14'(MAX_YEAR - $urandom_range(3));
      2:       y = 14'($urandom_range(3));
      default: y = 14'($urandom_range(MAX_YEAR));
    endcase
    m = 4'($urandom_range(1, 12));
    d = 5'(($urandom_range(9) < 7) ? $urandom_range(1, 28) : $urandom_range(29, 31));
  endfunction

  function automatic in_item_t random_word();
    in_item_t    w;
    int unsigned pick;
    w = '0;
    pick = $urandom_range(99);
    if (pick < 30)      w.opcode = OPC_DIFF;
    else if (pick < 63) w.opcode = OPC_ADD;
    else if (pick < 96) w.opcode = OPC_SUB;
    else                w.opcode = OPC_NONE;
    random_date(w.day_a, w.month_a, w.year_a);
    random_date(w.day_b, w.month_b, w.year_b);
    case ($urandom_range(9))
      0, 1, 2, 3: w.day_count = 22'($urandom_range(400));
      4, 5:       w.day_count = 22'($urandom_range(40000));
      6, 7:       w.day_count = 22'($urandom_range(3652425));
      8:          w.day_count = 22'($urandom);
      default:    w.day_count = 22'(3652424 - $urandom_range(2000));
    endcase
    // Noise: raw bits in one date field.
    if ($urandom_range(99) < 10) begin
      case ($urandom_range(5))
        0: w.day_a   = 5'($urandom);
        1: w.month_a = 4'($urandom);
        2: w.year_a  = 14'($urandom);
        3: w.day_b   = 5'($urandom);
        4: w.month_b = 4'($urandom);
        default: w.year_b = 14'($urandom);
      endcase
    end
    if (w.opcode != OPC_DIFF && $urandom_range(3) == 0) begin
      w.day_b   = 5'($urandom);
      w.month_b = 4'($urandom);
      w.year_b  = 14'($urandom);
    end
    if (w.opcode == OPC_NONE && $urandom_range(1) == 0) begin
      w = {OPC_NONE, 66'({$urandom, $urandom, $urandom})};
    end
    return w;
  endfunction

  // Offers one word and returns at the edge where it is taken.
  task automatic send_word(in_item_t w);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  initial begin : stimulus
    in_item_t directed[$];
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extremes of the calendar, invalid dates, out-of-range results and the
    // unused opcode.
    directed.push_back(make_word(OPC_DIFF, 1, 1, 0, 31, 12, 9999, 0));
    directed.push_back(make_word(OPC_DIFF, 31, 12, 9999, 1, 1, 0, 0));
    directed.push_back(make_word(OPC_DIFF, 29, 2, 2000, 1, 3, 1900, 0));
    directed.push_back(make_word(OPC_DIFF, 15, 6, 2024, 15, 6, 2024, 0));
    directed.push_back(make_word(OPC_DIFF, 29, 2, 1900, 1, 1, 2000, 0));
    directed.push_back(make_word(OPC_DIFF, 1, 1, 2000, 31, 4, 2000, 0));
    directed.push_back(make_word(OPC_DIFF, 29, 2, 0, 1, 3, 0, 0));
    directed.push_back(make_word(OPC_ADD, 0, 1, 2000, 0, 0, 0, 5));
    directed.push_back(make_word(OPC_ADD, 1, 0, 2000, 0, 0, 0, 5));
    directed.push_back(make_word(OPC_SUB, 1, 13, 2000, 0, 0, 0, 5));
    directed.push_back(make_word(OPC_ADD, 31, 15, 16383, 31, 15, 16383, 4194303));
    directed.push_back(make_word(OPC_ADD, 1, 1, 10000, 0, 0, 0, 1));
    directed.push_back(make_word(OPC_ADD, 1, 1, 0, 0, 0, 0, 0));
    directed.push_back(make_word(OPC_ADD, 1, 1, 0, 0, 0, 0, 3652424));
    directed.push_back(make_word(OPC_ADD, 31, 12, 9999, 0, 0, 0, 1));
    directed.push_back(make_word(OPC_ADD, 31, 12, 9999, 0, 0, 0, 0));
    directed.push_back(make_word(OPC_ADD, 28, 2, 1900, 0, 0, 0, 1));
    directed.push_back(make_word(OPC_ADD, 31, 12, 1999, 0, 0, 0, 60));
    directed.push_back(make_word(OPC_ADD, 1, 1, 0, 0, 0, 0, 4194303));
    directed.push_back(make_word(OPC_SUB, 1, 1, 0, 0, 0, 0, 1));
    directed.push_back(make_word(OPC_SUB, 1, 1, 0, 0, 0, 0, 0));
    directed.push_back(make_word(OPC_SUB, 31, 12, 9999, 0, 0, 0, 3652424));
    directed.push_back(make_word(OPC_SUB, 31, 12, 9999, 0, 0, 0, 3652425));
    directed.push_back(make_word(OPC_SUB, 1, 3, 2000, 31, 15, 16383, 1));
    directed.push_back(make_word(OPC_NONE, 31, 15, 16383, 31, 15, 16383, 4194303));
    directed.push_back(make_word(OPC_NONE, 0, 0, 0, 0, 0, 0, 0));
    foreach (directed[i]) send_word(directed[i]);

    // Random phases; the first one also carries the long output hold-off.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  long_hold_req = 1'b1; end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      repeat (PHASE_WORDS) send_word(random_word());
    end
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d result words: directed date extremes, invalid dates,", checked);
    $display("range errors and random words under four idle/stall mixes and a long hold.");
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
